// ===== hw/rtl/zspf_pkg.sv =====
package zspf_pkg;

  // Input item kinds, carried on s_tuser.
  localparam logic [1:0] CMD_TILE_WR = 2'd0;
  localparam logic [1:0] CMD_PIX_WR  = 2'd1;
  localparam logic [1:0] CMD_RENDER  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ZOOM   = 2'd0;
  localparam logic [1:0] REG_XPOS   = 2'd1;
  localparam logic [1:0] REG_YPOS   = 2'd2;
  localparam logic [1:0] REG_FLIP_X = 2'd3;

  // Tile RAM: 512 tiles of four bytes each.
  localparam int TILE_ROWS   = 512;
  localparam int TILE_ROW_W  = 9;

  // Geometry constants of the start point derivation.
  localparam logic signed [31:0] X_ORIGIN      = 32'sd4096;
  localparam logic signed [31:0] X_WRAP_LIMIT  = 32'sd3588;
  localparam logic signed [31:0] Y_WRAP_BASE   = -32'sd256;
  localparam logic signed [31:0] Y_WRAP_STEP   = 32'sd512;
  localparam logic signed [31:0] Y_OFFSET      = 32'sd12;
  localparam logic [31:0]        X_ZOOM_SCALE  = 32'd3740;
  localparam logic [31:0]        Y_ZOOM_SCALE  = 32'd846;
  localparam logic [31:0]        X_FLIP_BASE   = 32'h007F_FFFF;
  localparam logic [2:0]         PEN_CLEAR     = 3'd7;

  // Start point and mode derived from the configuration registers.
  typedef struct packed {
    logic [31:0] startx;
    logic [31:0] starty;
    logic        flip;
    logic        zoom_nz;
  } geom_t;

  // Stage load enables from the pipeline control.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

  // Item leaving the coordinate stage.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [18:0] addr;
    logic [7:0]  data;
    logic        inrange;
    logic [2:0]  px;
    logic [2:0]  py;
  } item2_t;

  // Item leaving the pixel fetch stage.
  typedef struct packed {
    logic [1:0] cmd;
    logic       drawable;
    logic [4:0] colour;
    logic [2:0] pix;
  } item3_t;

endpackage

// ===== hw/rtl/zoomed_sprite_pixel_fetch.sv =====
// Zoomed sprite pixel fetch. Items on the input stream either load the tile
// RAM (one byte each), load the 3-bit pixel memory, or render one screen
// point; only render items give a result, with pen = colour*8 + pixel and a
// drawn flag. The block takes one item per clock while the output is not
// stalled, and an item passes through an input stage with the zoom products,
// a coordinate stage that reads the tile RAM, a stage that reads the pixel
// memory, and the output register. Each memory is read once per item, which
// is what lets an item enter every cycle. After reset the tile RAM is
// cleared, one tile per cycle, and no item is taken during that time;
// configuration writes are taken at any time and must be made while no item
// is in flight, and before the next item, since the start point is registered.
module zoomed_sprite_pixel_fetch #(
  parameter int TILE_CODES    = 8192,
  parameter int SOURCE_WIDTH  = 128,
  parameter int SOURCE_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // address[18:0], data[26:19], screen_x[34:27],
                                // screen_y[42:35], zero pad[47:43]
  input  logic [1:0]  s_tuser,  // command[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // pen[7:0]
  output logic        m_tuser   // drawn[0]
);
  import zspf_pkg::*;

  // Configuration registers.
  logic [11:0] zoom;
  logic [11:0] x_position;
  logic [8:0]  y_position;
  logic        flip_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom       <= '0;
      x_position <= '0;
      y_position <= '0;
      flip_x     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZOOM:   zoom       <= cfg_data;
        REG_XPOS:   x_position <= cfg_data;
        REG_YPOS:   y_position <= cfg_data[8:0];
        REG_FLIP_X: flip_x     <= cfg_data[0];
      endcase
    end
  end

  geom_t      geom;
  pipe_ctrl_t ctrl;
  item2_t     item2;
  item3_t     item3;
  logic [3:0][7:0] tile_q;
  logic       clearing;

  zspf_geom u_geom (
    .clk        (clk),
    .zoom       (zoom),
    .x_position (x_position),
    .y_position (y_position),
    .flip_x     (flip_x),
    .geom       (geom)
  );

  zspf_map #(
    .SOURCE_WIDTH  (SOURCE_WIDTH),
    .SOURCE_HEIGHT (SOURCE_HEIGHT)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .geom     (geom),
    .zoom     (zoom),
    .cmd      (s_tuser),
    .addr     (s_tdata[18:0]),
    .data     (s_tdata[26:19]),
    .screen_x (s_tdata[34:27]),
    .screen_y (s_tdata[42:35]),
    .item2    (item2),
    .tile_q   (tile_q),
    .clearing (clearing)
  );

  zspf_pixel #(
    .TILE_CODES (TILE_CODES)
  ) u_pixel (
    .clk    (clk),
    .ctrl   (ctrl),
    .geom   (geom),
    .item2  (item2),
    .tile_q (tile_q),
    .item3  (item3)
  );

  // Stage valid bits and the advance chain; bubbles close up under a stall.
  logic v1;
  logic v2;
  logic v3;
  logic out_free;
  logic go1;
  logic go2;
  logic go3;
  logic render3;

  assign render3  = (item3.cmd == CMD_RENDER);
  assign out_free = !m_tvalid || m_tready;
  assign go3      = v3 && (!render3 || out_free);
  assign go2      = v2 && (!v3 || go3);
  assign go1      = v1 && (!v2 || go2);
  assign s_tready = (!v1 || go1) && !clearing;

  assign ctrl.ld1 = s_tvalid && s_tready;
  assign ctrl.ld2 = go1;
  assign ctrl.ld3 = go2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctrl.ld1) begin
        v1 <= 1'b1;
      end else if (go1) begin
        v1 <= 1'b0;
      end
      if (go1) begin
        v2 <= 1'b1;
      end else if (go2) begin
        v2 <= 1'b0;
      end
      if (go2) begin
        v3 <= 1'b1;
      end else if (go3) begin
        v3 <= 1'b0;
      end
    end
  end

  // Output register; only render items reach it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go3 && render3) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go3 && render3) begin
      if (item3.drawable && (item3.pix != PEN_CLEAR)) begin
        m_tdata <= {item3.colour, item3.pix};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end
    end
  end

  // No item is taken while the tile RAM is being cleared.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("item accepted during tile RAM clearing");

  // A render item waiting on a full output register stays in its stage.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && render3 && m_tvalid && !m_tready) |=> v3)
    else $error("render item dropped under output stall");

  // A new result always comes from a render item in the last stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v3 && render3))
    else $error("result produced without a render item");

endmodule

// ===== hw/rtl/zspf_geom.sv =====
module zspf_geom (
  input  logic               clk,
  input  logic [11:0]        zoom,
  input  logic [11:0]        x_position,
  input  logic [8:0]         y_position,
  input  logic               flip_x,
  output zspf_pkg::geom_t    geom
);
  import zspf_pkg::*;

  geom_t geom_next;

  // Start point in 16.16 fixed point from position, zoom and flip.
  always_comb begin
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [31:0]        sxu;
    logic [31:0]        syu;
    logic [31:0]        stx;
    logic [31:0]        sty;
    sx = X_ORIGIN - $signed({20'd0, x_position});
    if (sx > X_WRAP_LIMIT) begin
      sx = sx - X_ORIGIN;
    end
    sy = 32'sd0 - $signed({23'd0, y_position});
    if (sy <= (Y_WRAP_BASE + $signed({26'd0, zoom[11:6]}))) begin
      sy = sy + Y_WRAP_STEP;
    end
    sy  = sy + Y_OFFSET;
    sxu = unsigned'(sx);
    syu = unsigned'(sy);
    stx = (32'd0 - (sxu << 14)) + (X_ZOOM_SCALE * {20'd0, zoom});
    if (flip_x) begin
      stx = X_FLIP_BASE - stx;
    end
    sty = (32'd0 - (syu << 16)) + (Y_ZOOM_SCALE * {20'd0, zoom});
    geom_next.startx  = stx;
    geom_next.starty  = sty;
    geom_next.flip    = flip_x;
    geom_next.zoom_nz = (zoom != 12'd0);
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

// ===== hw/rtl/zspf_map.sv =====
module zspf_map #(
  parameter int SOURCE_WIDTH  = 128,
  parameter int SOURCE_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  zspf_pkg::pipe_ctrl_t  ctrl,
  input  zspf_pkg::geom_t       geom,
  input  logic [11:0]           zoom,
  input  logic [1:0]            cmd,
  input  logic [18:0]           addr,
  input  logic [7:0]            data,
  input  logic [7:0]            screen_x,
  input  logic [7:0]            screen_y,
  output zspf_pkg::item2_t      item2,
  output logic [3:0][7:0]       tile_q,
  output logic                  clearing
);
  import zspf_pkg::*;

  localparam logic [15:0] SRC_W = 16'(SOURCE_WIDTH);
  localparam logic [15:0] SRC_H = 16'(SOURCE_HEIGHT);

  // First stage: item fields and the screen point scaled by zoom.
  logic [1:0]  s1_cmd;
  logic [18:0] s1_addr;
  logic [7:0]  s1_data;
  logic [19:0] s1_xprod;
  logic [19:0] s1_yprod;

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      s1_cmd   <= cmd;
      s1_addr  <= addr;
      s1_data  <= data;
      s1_xprod <= {12'd0, screen_x} * {8'd0, zoom};
      s1_yprod <= {12'd0, screen_y} * {8'd0, zoom};
    end
  end

  // Source point, range check and tile address.
  logic [31:0]           cx;
  logic [31:0]           cy;
  logic [15:0]           px;
  logic [15:0]           py;
  logic [TILE_ROW_W-1:0] tile_row;

  always_comb begin
    logic [31:0] xoff;
    logic [31:0] yoff;
    xoff = {6'd0, s1_xprod, 6'd0};
    yoff = {6'd0, s1_yprod, 6'd0};
    cx   = geom.flip ? (geom.startx - xoff) : (geom.startx + xoff);
    cy   = geom.starty + yoff;
    px   = cx[31:16];
    py   = cy[31:16];
    tile_row = {py[7:3], px[6:3]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      item2.cmd     <= s1_cmd;
      item2.addr    <= s1_addr;
      item2.data    <= s1_data;
      item2.inrange <= (px < SRC_W) && (py < SRC_H);
      item2.px      <= px[2:0];
      item2.py      <= py[2:0];
    end
  end

  // Clearing pass over the tile RAM after reset, one tile per cycle.
  logic [TILE_ROW_W:0] clr_cnt;

  assign clearing = !clr_cnt[TILE_ROW_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Tile RAM, byte writes and whole-tile reads in stage order.
  logic [3:0][7:0] tile_mem [TILE_ROWS];

  always_ff @(posedge clk) begin
    if (clearing) begin
      tile_mem[clr_cnt[TILE_ROW_W-1:0]] <= '0;
    end else if (ctrl.ld2 && (s1_cmd == CMD_TILE_WR)) begin
      tile_mem[s1_addr[10:2]][s1_addr[1:0]] <= s1_data;
    end
    if (ctrl.ld2) begin
      tile_q <= tile_mem[tile_row];
    end
  end

endmodule

// ===== hw/rtl/zspf_pixel.sv =====
module zspf_pixel #(
  parameter int TILE_CODES = 8192
) (
  input  logic                  clk,
  input  zspf_pkg::pipe_ctrl_t  ctrl,
  input  zspf_pkg::geom_t       geom,
  input  zspf_pkg::item2_t      item2,
  input  logic [3:0][7:0]       tile_q,
  output zspf_pkg::item3_t      item3
);
  import zspf_pkg::*;

  localparam int          PIX_DEPTH = TILE_CODES * 64;
  localparam int          PIX_AW    = $clog2(PIX_DEPTH);
  localparam int          CODE_W    = PIX_AW - 6;
  localparam logic [19:0] PIX_LIMIT = 20'(PIX_DEPTH);
  localparam logic [15:0] CODE_M1   = 16'(TILE_CODES);
  localparam logic [15:0] CODE_M2   = 16'(2 * TILE_CODES);
  localparam logic [15:0] CODE_M4   = 16'(4 * TILE_CODES);

  // Tile code reduced into the code range, column mirror, pixel address.
  logic [PIX_AW-1:0] rd_addr;

  always_comb begin
    logic [15:0] cv;
    logic [2:0]  col;
    cv = {3'd0, tile_q[1][4:0], tile_q[0]};
    if (cv >= CODE_M4) begin
      cv = cv - CODE_M4;
    end
    if (cv >= CODE_M2) begin
      cv = cv - CODE_M2;
    end
    if (cv >= CODE_M1) begin
      cv = cv - CODE_M1;
    end
    col     = tile_q[3][7] ? ~item2.px : item2.px;
    rd_addr = {cv[CODE_W-1:0], item2.py, col};
  end

  // Pixel memory; entries beyond the code range are never read.
  logic [2:0] pix_mem [PIX_DEPTH];
  logic       wr_ok;

  assign wr_ok = ({1'b0, item2.addr} < PIX_LIMIT);

  always_ff @(posedge clk) begin
    if (ctrl.ld3 && (item2.cmd == CMD_PIX_WR) && wr_ok) begin
      pix_mem[item2.addr[PIX_AW-1:0]] <= item2.data[2:0];
    end
  end

  // Stage register, together with the pixel read for this item.
  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      item3.cmd      <= item2.cmd;
      item3.drawable <= item2.inrange && geom.zoom_nz;
      item3.colour   <= tile_q[3][4:0];
      item3.pix      <= pix_mem[rd_addr];
    end
  end

endmodule
